// ===== rtl/core/vco_pitch_calibrator_macros.svh =====
// Assertion macros for the pitch calibrator.
`ifndef VCO_PITCH_CALIBRATOR_MACROS_SVH
`define VCO_PITCH_CALIBRATOR_MACROS_SVH
`ifndef SYNTHESIS
`define VPC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define VPC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define VPC_ASSERT_IMP(label, clk, rst_n, a, c)
`define VPC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/core/vpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_pkg
// Shared types and constants of the pitch calibrator.
// ----------------------------------------------------------------------------
package vpc_pkg;
  localparam int WINDOW_SIZE = 17;
  localparam int NOTE_SLOTS  = 64;
  localparam int NOTE_W      = 6;
  localparam int WIN_W       = $clog2(WINDOW_SIZE + 1);
  localparam logic [20:0] FREQ_NUM = 21'd2048000;
  localparam logic [19:0] FREQ_MAX = 20'hFFFFF;
  localparam logic [24:0] SUM_MAX  = 25'h1FFFFFF;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_START  = 2'd3;

  localparam logic [2:0] REG_LEVEL = 3'd0;
  localparam logic [2:0] REG_HYST  = 3'd1;
  localparam logic [2:0] REG_TOL   = 3'd2;
  localparam logic [2:0] REG_STEP  = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;
  localparam logic [2:0] REG_LAST  = 3'd5;

  typedef struct packed {
    logic capture;    // register the accepted item
    logic sample_go;  // crossing step on the captured sample
    logic div_start;
    logic div_step;
    logic accum;      // fold the quotient into the window
    logic eval;       // compare and update code / note
    logic mem_rd;     // read code memory at current note
    logic finish;     // produce the result
  } vpc_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       running;
    logic       falling;    // falling crossing found
    logic       window_full;
    logic       div_done;
  } vpc_sts_t;
endpackage

// ===== rtl/core/vpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_datapath
// Crossing detection, period divider, window average and code stepping.
// ----------------------------------------------------------------------------
`include "vco_pitch_calibrator_macros.svh"
module vpc_datapath import vpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  vpc_cmd_t    cmd,
  output vpc_sts_t    sts,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_sample,
  input  logic [5:0]  in_note_sel,
  input  logic [19:0] in_target_freq,
  input  logic [15:0] in_code_in,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        out_dac_write,
  output logic [15:0] out_dac_value,
  output logic [5:0]  out_current_note,
  output logic        out_busy_res,
  output logic        out_finished,
  output logic [15:0] out_read_code
);
  logic [15:0] level_r, step_cfg_r;
  logic [14:0] hyst_r;
  logic [19:0] tol_r;
  logic [7:0]  limit_r;
  logic [5:0]  last_r;

  logic [1:0]  act_r;
  logic [15:0] smp_r;
  logic [5:0]  sel_r;

  logic [15:0] codes_mem [NOTE_SLOTS];
  logic [19:0] tgts_mem [NOTE_SLOTS];
  logic [15:0] mcode_r, rdc_r;
  logic [19:0] mtgt_r;

  logic [24:0] sum_r;
  logic [WIN_W-1:0] win_r;
  logic [15:0] per_r, prev_r, step_r;
  logic        high_r;
  logic [19:0] avg_r, pavg_r;
  logic [7:0]  att_r;
  logic [5:0]  note_r;
  logic        run_r, done_r, wr_r;

  // restoring divider for 2048000/period
  logic [24:0] dq_r, ddiv_r;
  logic [25:0] drem_r;
  logic [4:0]  dcnt_r;
  logic [25:0] dtrial;

  logic signed [17:0] hi_b, lo_b, cur_s, prv_s;
  logic rising, falling;

  always_comb begin
    hi_b  = $signed({2'b0, level_r}) + $signed({3'b0, hyst_r});
    lo_b  = $signed({2'b0, level_r}) - $signed({3'b0, hyst_r});
    cur_s = $signed({2'b0, smp_r});
    prv_s = $signed({2'b0, prev_r});
    rising  = cur_s >= hi_b && prv_s < hi_b && !high_r;
    falling = !rising && cur_s <= lo_b && prv_s > lo_b && high_r;
    dtrial  = {drem_r[24:0], dq_r[24]} - {1'b0, ddiv_r};
  end

  assign sts.action      = act_r;
  assign sts.running     = run_r;
  assign sts.falling     = falling;
  assign sts.window_full = win_r >= WIN_W'(WINDOW_SIZE);
  assign sts.div_done    = dcnt_r == 5'd0;

  logic [24:0] fq, avg_w;
  logic [19:0] avg_n;
  logic signed [21:0] up_b, dn_b, a_s, p_s;
  logic [16:0] code_up;
  logic [15:0] stp_h, stp_dn, stp_up, code_new;
  logic        hit;

  always_comb begin
    fq = (dq_r > 25'(FREQ_MAX)) ? 25'(FREQ_MAX) : dq_r;
    // The window length less one is a power of two, so this is a shift.
    avg_w = sum_r / 25'(WINDOW_SIZE - 1);
    avg_n = (avg_w > 25'(FREQ_MAX)) ? FREQ_MAX : avg_w[19:0];
    up_b = $signed({2'b0, mtgt_r}) + $signed({2'b0, tol_r});
    dn_b = $signed({2'b0, mtgt_r}) - $signed({2'b0, tol_r});
    a_s  = $signed({2'b0, avg_n});
    p_s  = $signed({2'b0, avg_r});
    stp_h = (step_r >> 1) + 16'd1;
    hit = (a_s <= up_b && a_s >= dn_b) || att_r > limit_r;
    stp_dn = (p_s < dn_b) ? stp_h : step_r;
    stp_up = (p_s > up_b) ? stp_h : step_r;
    code_up = {1'b0, mcode_r} + {1'b0, stp_up};
    if (hit) code_new = mcode_r;
    else if (a_s > up_b) code_new = (mcode_r > stp_dn) ? mcode_r - stp_dn : 16'd0;
    else if (a_s < dn_b) code_new = code_up[16] ? 16'hFFFF : code_up[15:0];
    else code_new = mcode_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action; smp_r <= in_sample; sel_r <= in_note_sel;
    end
    if (cmd.mem_rd) begin
      mcode_r <= codes_mem[note_r];
      mtgt_r  <= tgts_mem[note_r];
      rdc_r   <= codes_mem[sel_r];
    end
    if (cmd.capture && in_action == ACT_LOAD) begin
      codes_mem[in_note_sel] <= in_code_in;
      tgts_mem[in_note_sel]  <= in_target_freq;
    end else if (cmd.eval && !hit) begin
      codes_mem[note_r] <= code_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 16'd32768; hyst_r <= 15'd1000; tol_r <= 20'd26;
      step_cfg_r <= 16'd100; limit_r <= 8'd20; last_r <= 6'd59;
      sum_r <= '0; win_r <= '0; per_r <= '0; prev_r <= '0; high_r <= 1'b0;
      avg_r <= '0; pavg_r <= '0; step_r <= 16'd100; att_r <= '0; note_r <= '0;
      run_r <= 1'b0; done_r <= 1'b0; wr_r <= 1'b0; dcnt_r <= '0;
      out_dac_write <= 1'b0; out_busy_res <= 1'b0; out_finished <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEVEL: level_r    <= cfg_data[15:0];
          REG_HYST:  hyst_r     <= cfg_data[14:0];
          REG_TOL:   tol_r      <= cfg_data;
          REG_STEP:  step_cfg_r <= cfg_data[15:0];
          REG_LIMIT: limit_r    <= cfg_data[7:0];
          REG_LAST:  last_r     <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        wr_r <= in_action == ACT_START;
        if (in_action == ACT_START) begin
          run_r <= 1'b1; done_r <= 1'b0; note_r <= '0; att_r <= '0;
          step_r <= step_cfg_r; win_r <= '0; sum_r <= '0; per_r <= '0;
          high_r <= 1'b0; avg_r <= '0; pavg_r <= '0;
        end
      end
      if (cmd.sample_go) begin
        if (rising) high_r <= 1'b1;
        else if (falling) high_r <= 1'b0;
        prev_r <= smp_r;
        if (falling) per_r <= 16'd1;
        else if (per_r != 16'hFFFF) per_r <= per_r + 16'd1;
      end
      if (cmd.div_start) begin
        dq_r <= {4'b0, FREQ_NUM}; drem_r <= '0; dcnt_r <= 5'd25;
        ddiv_r <= (per_r == 16'd0) ? 25'd1 : {9'b0, per_r};
      end
      if (cmd.div_step && dcnt_r != 5'd0) begin
        dcnt_r <= dcnt_r - 5'd1;
        if (!dtrial[25]) begin
          drem_r <= dtrial; dq_r <= {dq_r[23:0], 1'b1};
        end else begin
          drem_r <= {drem_r[24:0], dq_r[24]}; dq_r <= {dq_r[23:0], 1'b0};
        end
      end
      if (cmd.accum) begin
        if (win_r != '0)
          sum_r <= ({1'b0, sum_r} + {6'b0, fq[19:0]} > {1'b0, SUM_MAX}) ?
                   SUM_MAX : sum_r + {5'b0, fq[19:0]};
        win_r <= win_r + WIN_W'(1);
      end
      if (cmd.eval) begin
        pavg_r <= avg_r; avg_r <= avg_n; sum_r <= '0; win_r <= '0;
        wr_r <= 1'b1;
        if (hit && note_r < last_r && note_r != 6'(NOTE_SLOTS - 1)) att_r <= 8'd1;
        else if (att_r != 8'hFF) att_r <= att_r + 8'd1;
        if (hit) begin
          if (note_r < last_r && note_r != 6'(NOTE_SLOTS - 1)) begin
            step_r <= step_cfg_r; note_r <= note_r + 6'd1;
          end else begin
            run_r <= 1'b0; done_r <= 1'b1; note_r <= '0;
          end
        end else if (a_s > up_b) begin
          if (p_s < dn_b) step_r <= stp_h;
        end else if (a_s < dn_b) begin
          if (p_s > up_b) step_r <= stp_h;
        end
      end
      if (cmd.finish) begin
        out_dac_write <= wr_r; out_busy_res <= run_r; out_finished <= done_r;
      end
    end
  end

  // result payload follows the final memory read
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_dac_value    <= mcode_r;
      out_current_note <= note_r;
      out_read_code    <= (act_r == ACT_READ) ? rdc_r : 16'd0;
    end
  end

  `VPC_ASSERT_NXT(a_start_runs, clk, rst_n, cmd.capture && in_action == ACT_START, run_r)
  `VPC_ASSERT_IMP(a_win_bound, clk, rst_n, 1'b1, win_r <= WIN_W'(WINDOW_SIZE))
  `VPC_ASSERT_IMP(a_run_done, clk, rst_n, 1'b1, !(run_r && done_r))
endmodule

// ===== rtl/core/vpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_ctrl
// Sequencer: accepts an item, drives the datapath, presents the result.
// ----------------------------------------------------------------------------
`include "vco_pitch_calibrator_macros.svh"
module vpc_ctrl import vpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  vpc_sts_t sts,
  output vpc_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SMP  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_AVG  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_EVAL = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;
  logic       take;

  // a result may wait in the output register while the next item is taken
  assign in_stall  = st_r != S_IDLE;
  assign take      = in_valid && !in_stall;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    st_nxt = st_r;
    ov_nxt = ov_r && out_stall;
    unique case (st_r)
      S_IDLE: if (take) begin
        cmd.capture = 1'b1; st_nxt = S_SMP;
      end
      S_SMP: begin
        if (sts.action == ACT_SAMPLE && sts.running) begin
          cmd.sample_go = 1'b1;
          if (sts.falling) begin
            cmd.div_start = 1'b1; st_nxt = S_DIV;
          end else st_nxt = S_RD;
        end else st_nxt = S_RD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_step = 1'b0; st_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1; st_nxt = S_AVG;
      end
      S_AVG: begin
        if (sts.window_full) begin
          cmd.mem_rd = 1'b1; st_nxt = S_EVAL;
        end else st_nxt = S_RD;
      end
      S_EVAL: begin
        cmd.eval = 1'b1; st_nxt = S_RD;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        if (!(ov_r && out_stall)) st_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.finish = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end

  `VPC_ASSERT_IMP(a_busy_stall, clk, rst_n, st_r != S_IDLE, in_stall)
  `VPC_ASSERT_NXT(a_out_set, clk, rst_n, st_r == S_OUT, out_valid)
  `VPC_ASSERT_IMP(a_no_overwrite, clk, rst_n, st_r == S_OUT, !(ov_r && out_stall))
endmodule

// ===== rtl/core/vco_pitch_calibrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vco_pitch_calibrator
// Oscillator pitch calibration by DAC code search over a table of notes.
// ----------------------------------------------------------------------------
// Each transfer gives one result. A load, read, start or a sample without a
// falling crossing passes through capture, the memory read and the output
// step; a falling crossing adds the period-to-frequency divider (one quotient
// bit a cycle) and the window update, and the crossing that completes the
// window adds the comparison against the note target.
// A finished result may wait in the output register while the next item is
// taken and processed up to its own result.
module vco_pitch_calibrator import vpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_sample,
  input  logic [5:0]  in_note_sel,
  input  logic [19:0] in_target_freq,
  input  logic [15:0] in_code_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dac_write,
  output logic [15:0] out_dac_value,
  output logic [5:0]  out_current_note,
  output logic        out_busy_res,
  output logic        out_finished,
  output logic [15:0] out_read_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  vpc_cmd_t cmd;
  vpc_sts_t sts;

  vpc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  vpc_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_action, .in_sample, .in_note_sel,
    .in_target_freq, .in_code_in, .cfg_we, .cfg_index, .cfg_data,
    .out_dac_write, .out_dac_value, .out_current_note, .out_busy_res,
    .out_finished, .out_read_code
  );
endmodule
